// ----- rtl/core/mtht_pkg.sv -----
// Shared types and constants for the motion trigger hold timer core.
// Used by every module under rtl/core; depends on nothing else.
package mtht_pkg;

  // field widths
  localparam int MOTION_WIDTH = 16;
  localparam int TIME_WIDTH   = 32;
  localparam int THR_WIDTH    = 16;
  localparam int CNT_WIDTH    = 8;
  localparam int DLY_WIDTH    = 16;

  // magnitude sum keeps one bit more than a motion component
  localparam int SUM_WIDTH = MOTION_WIDTH + 1;
  // threshold compares are made against twice the threshold
  localparam int CMP_WIDTH = (SUM_WIDTH > THR_WIDTH + 1) ? SUM_WIDTH : THR_WIDTH + 1;

  // stream payload widths, padded to whole bytes
  localparam int IN_RAW_W   = 2 * MOTION_WIDTH + TIME_WIDTH;
  localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = MOTION_WIDTH + 5;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOW_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_TRIG = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS  = 3'd4;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [THR_WIDTH-1:0] MOTION_THR_RST  = 16'd128;
  localparam logic [THR_WIDTH-1:0] FLOW_THR_RST    = 16'd256;
  localparam logic [CNT_WIDTH-1:0] FRAMES_TRIG_RST = 8'd3;
  localparam logic [DLY_WIDTH-1:0] HOLD_MS_RST     = 16'd5000;
  localparam logic [DLY_WIDTH-1:0] TIMEOUT_MS_RST  = 16'd1000;

  // configuration bundle
  typedef struct packed {
    logic [THR_WIDTH-1:0] motion_thr;
    logic [THR_WIDTH-1:0] flow_thr;
    logic [CNT_WIDTH-1:0] frames_trig;
    logic [DLY_WIDTH-1:0] hold_ms;
    logic [DLY_WIDTH-1:0] timeout_ms;
  } cfg_t;

  // front stage to decision stage
  typedef struct packed {
    logic                  valid;
    logic [SUM_WIDTH-1:0]  sum;
    logic [TIME_WIDTH-1:0] time_ms;
  } front_t;

endpackage

// ----- rtl/core/mtht_cfg.sv -----
// Configuration register file for the motion trigger hold timer.
// Depends on mtht_pkg for register indexes, widths and reset values.
module mtht_cfg
  import mtht_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  // write the addressed register, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motion_thr  <= MOTION_THR_RST;
      cfg_r.flow_thr    <= FLOW_THR_RST;
      cfg_r.frames_trig <= FRAMES_TRIG_RST;
      cfg_r.hold_ms     <= HOLD_MS_RST;
      cfg_r.timeout_ms  <= TIMEOUT_MS_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_MOTION_THR:  cfg_r.motion_thr  <= wr_data[THR_WIDTH-1:0];
        REG_FLOW_THR:    cfg_r.flow_thr    <= wr_data[THR_WIDTH-1:0];
        REG_FRAMES_TRIG: cfg_r.frames_trig <= wr_data[CNT_WIDTH-1:0];
        REG_HOLD_MS:     cfg_r.hold_ms     <= wr_data[DLY_WIDTH-1:0];
        REG_TIMEOUT_MS:  cfg_r.timeout_ms  <= wr_data[DLY_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/mtht_front.sv -----
// Input register stage: captures a request and forms |x|+|y|.
// Depends on mtht_pkg for widths and the front_t bundle.
module mtht_front
  import mtht_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [MOTION_WIDTH-1:0] motion_x,
  input  logic [MOTION_WIDTH-1:0] motion_y,
  input  logic [TIME_WIDTH-1:0]   time_ms,
  input  logic                    advance,
  output front_t                  front
);

  logic                    valid_r, valid_nxt;
  logic [SUM_WIDTH-1:0]    sum_r, sum_nxt;
  logic [TIME_WIDTH-1:0]   time_r;
  logic [MOTION_WIDTH-1:0] mag_x, mag_y;
  logic                    take;

  // two's complement magnitude; the most negative code maps to 2^(W-1)
  assign mag_x = motion_x[MOTION_WIDTH-1] ? (~motion_x + 1'b1) : motion_x;
  assign mag_y = motion_y[MOTION_WIDTH-1] ? (~motion_y + 1'b1) : motion_y;
  assign sum_nxt = SUM_WIDTH'(mag_x) + SUM_WIDTH'(mag_y);

  // accept while the stage is empty or drains this cycle
  assign in_ready  = !valid_r || advance;
  assign take      = in_valid && in_ready;
  assign valid_nxt = take ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // hold payload until the next request is taken
  always_ff @(posedge clk) begin
    if (take) begin
      sum_r  <= sum_nxt;
      time_r <= time_ms;
    end
  end

  assign front.valid   = valid_r;
  assign front.sum     = sum_r;
  assign front.time_ms = time_r;

endmodule

// ----- rtl/core/mtht_decide.sv -----
// Decision stage: threshold compares, counter, hold timer and result register.
// Depends on mtht_pkg for widths, cfg_t and front_t.
module mtht_decide
  import mtht_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  front_t                  front,
  output logic                    advance,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    triggered,
  output logic [MOTION_WIDTH-1:0] motion_level,
  output logic                    moving,
  output logic                    sound_start,
  output logic                    sound_stop,
  output logic                    flow_reset
);

  // persistent state
  logic [CNT_WIDTH-1:0]  count_r, count_nxt;
  logic [TIME_WIDTH-1:0] cmark_r, cmark_nxt;
  logic [TIME_WIDTH-1:0] tmark_r, tmark_nxt;
  logic                  trig_r, trig_nxt;

  // result register
  logic                    ovalid_r, ovalid_nxt;
  logic                    o_trig_r;
  logic [MOTION_WIDTH-1:0] o_level_r;
  logic                    o_moving_r, o_start_r, o_stop_r, o_flow_r;

  logic                  step;
  logic                  is_moving, is_flow;
  logic [THR_WIDTH:0]    motion_lim, flow_lim;
  logic                  count_expired, hold_expired;
  logic [CNT_WIDTH-1:0]  count_cur;
  logic                  start_nxt, stop_nxt;
  logic [TIME_WIDTH:0]   cmark_lim, tmark_lim;
  logic [TIME_WIDTH:0]   now_ext;

  // drain the front stage whenever the result register can take a value
  assign advance = !ovalid_r || out_ready;
  assign step    = front.valid && advance;

  // compare unhalved sum against twice the threshold
  assign motion_lim = {cfg.motion_thr, 1'b0};
  assign flow_lim   = {cfg.flow_thr, 1'b0};
  assign is_moving  = CMP_WIDTH'(front.sum) > CMP_WIDTH'(motion_lim);
  assign is_flow    = CMP_WIDTH'(front.sum) > CMP_WIDTH'(flow_lim);

  // timeouts: now > mark + delay, one bit wider so nothing wraps
  assign now_ext       = {1'b0, front.time_ms};
  assign cmark_lim     = {1'b0, cmark_r} + (TIME_WIDTH+1)'(cfg.timeout_ms);
  assign tmark_lim     = {1'b0, tmark_r} + (TIME_WIDTH+1)'(cfg.hold_ms);
  assign count_expired = now_ext > cmark_lim;
  assign hold_expired  = now_ext > tmark_lim;

  // next state for one frame
  always_comb begin
    count_cur = count_expired ? '0 : count_r;
    count_nxt = count_cur;
    cmark_nxt = cmark_r;
    tmark_nxt = tmark_r;
    trig_nxt  = trig_r;
    start_nxt = 1'b0;
    stop_nxt  = 1'b0;
    if (!trig_r && is_moving) begin
      if (count_cur < cfg.frames_trig) begin
        count_nxt = count_cur + 1'b1;
        cmark_nxt = front.time_ms;
      end else begin
        tmark_nxt = front.time_ms;
        trig_nxt  = 1'b1;
        start_nxt = 1'b1;
      end
    end else if (trig_r && is_moving) begin
      tmark_nxt = front.time_ms;
    end else if (trig_r && hold_expired) begin
      trig_nxt = 1'b0;
      stop_nxt = 1'b1;
    end
    // flow reset forces the trigger off
    if (is_flow) begin
      if (trig_nxt) begin
        stop_nxt = 1'b1;
      end
      trig_nxt = 1'b0;
    end
  end

  // advance state only for a frame that moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cmark_r <= '0;
      tmark_r <= '0;
      trig_r  <= 1'b0;
    end else if (step) begin
      count_r <= count_nxt;
      cmark_r <= cmark_nxt;
      tmark_r <= tmark_nxt;
      trig_r  <= trig_nxt;
    end
  end

  // result valid flag
  assign ovalid_nxt = step ? 1'b1 : (out_ready ? 1'b0 : ovalid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (step) begin
      o_trig_r   <= trig_nxt;
      o_level_r  <= front.sum[SUM_WIDTH-1:1];
      o_moving_r <= is_moving;
      o_start_r  <= start_nxt;
      o_stop_r   <= stop_nxt;
      o_flow_r   <= is_flow;
    end
  end

  assign out_valid    = ovalid_r;
  assign triggered    = o_trig_r;
  assign motion_level = o_level_r;
  assign moving       = o_moving_r;
  assign sound_start  = o_start_r;
  assign sound_stop   = o_stop_r;
  assign flow_reset   = o_flow_r;

endmodule

// ----- rtl/core/motion_trigger_hold_timer_core.sv -----
// Motion trigger hold timer: per-frame motion level, frame counter and trigger.
// Depends on mtht_pkg, mtht_cfg, mtht_front and mtht_decide.
//
// Usage:
//   in_*  : one request per camera frame: motion_x, motion_y (signed Q8.8)
//           and a millisecond timestamp. Accepted when in_tvalid && in_tready.
//   out_* : one result per request: trigger state, motion level (Q8.8),
//           moving flag, sound start/stop pulses and the flow reset pulse.
//   cfg_* : register writes (index, data), always ready; write only while
//           no request is in flight.
// From input accept to output valid a request passes the input register that
// forms |x|+|y|, then the decision logic feeding the result register.
// Throughput is one request per cycle while the receiver does not stall; the
// per-frame state is updated together with the result register.
// When the receiver stalls, the result register holds its value and the
// input register still takes one more request; then in_tready drops until
// out_tready returns. Reset clears the counter, both time marks, the trigger
// and all valid flags, and loads the registers with their defaults.
module motion_trigger_hold_timer_core
  import mtht_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata: motion_x [15:0], motion_y [31:16], time_ms [63:32]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tdata: triggered [0], motion_level [16:1], moving [17], sound_start [18],
  //        sound_stop [19], flow_reset [20], zero [23:21]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  front_t front;
  logic   advance;

  logic                    r_trig, r_moving, r_start, r_stop, r_flow;
  logic [MOTION_WIDTH-1:0] r_level;

  assign cfg_ready = 1'b1;

  mtht_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  mtht_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .motion_x (in_tdata[MOTION_WIDTH-1:0]),
    .motion_y (in_tdata[2*MOTION_WIDTH-1:MOTION_WIDTH]),
    .time_ms  (in_tdata[2*MOTION_WIDTH+TIME_WIDTH-1:2*MOTION_WIDTH]),
    .advance  (advance),
    .front    (front)
  );

  mtht_decide u_decide (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .front        (front),
    .advance      (advance),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .triggered    (r_trig),
    .motion_level (r_level),
    .moving       (r_moving),
    .sound_start  (r_start),
    .sound_stop   (r_stop),
    .flow_reset   (r_flow)
  );

  // pack the result, padding with zeros
  assign out_tdata = OUT_DATA_W'({r_flow, r_stop, r_start, r_moving, r_level, r_trig});

endmodule

// ----- test/motion_trigger_hold_timer_core_test.sv -----
// Self-checking testbench for motion_trigger_hold_timer_core: directed frames, then
// random phases of frames under random register settings, gaps and receiver stalls.
// Depends on mtht_pkg and the core; every result is checked against a local predictor.
module motion_trigger_hold_timer_core_test;
  import mtht_pkg::*;

  localparam int unsigned HALF_MAG = 1 << (MOTION_WIDTH - 1);
  localparam int unsigned SUM_MAX  = 1 << MOTION_WIDTH;

  typedef struct {
    logic                    triggered;
    logic [MOTION_WIDTH-1:0] level;
    logic                    moving;
    logic                    snd_start;
    logic                    snd_stop;
    logic                    flow_rst;
  } frame_verdict_t;

  typedef enum {SUM_QUIET, SUM_MOVING, SUM_FLOW, SUM_BORDER, SUM_NOISE} sum_kind_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // tdata: motion_x [15:0], motion_y [31:16], time_ms [63:32]
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // tdata: triggered [0], motion_level [16:1], moving [17], sound_start [18],
  //        sound_stop [19], flow_reset [20], zero [23:21]
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state and register copy
  cfg_t                  settings;
  logic [CNT_WIDTH-1:0]  hits;
  logic [TIME_WIDTH-1:0] hit_mark_ms;
  logic [TIME_WIDTH-1:0] motion_mark_ms;
  logic                  alarm_on;

  frame_verdict_t        pending_verdicts[$];
  int                    mismatches = 0;
  logic [TIME_WIDTH-1:0] t_now = '0;

  // sender and receiver pacing
  int                    gap_max = 3;
  int                    burst_left = 0;
  int                    stall_pct = 20;
  int                    stall_left = 0;
  int                    hold_left = 0;

  motion_trigger_hold_timer_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial forever #2 clk = ~clk;

  // abort a hung run
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [SUM_WIDTH-1:0] abs_q88(logic signed [MOTION_WIDTH-1:0] v);
    logic signed [MOTION_WIDTH:0] w;
    w = (MOTION_WIDTH + 1)'(v);
    return (w < 0) ? -w : w;
  endfunction

  // now > mark + delay with one spare bit, so the sum never wraps
  function automatic logic expired(logic [TIME_WIDTH-1:0] now, logic [TIME_WIDTH-1:0] mark,
                                   logic [DLY_WIDTH-1:0] delay);
    return {1'b0, now} > ({1'b0, mark} + (TIME_WIDTH + 1)'(delay));
  endfunction

  function automatic void reset_model();
    settings.motion_thr  = MOTION_THR_RST;
    settings.flow_thr    = FLOW_THR_RST;
    settings.frames_trig = FRAMES_TRIG_RST;
    settings.hold_ms     = HOLD_MS_RST;
    settings.timeout_ms  = TIMEOUT_MS_RST;
    hits           = '0;
    hit_mark_ms    = '0;
    motion_mark_ms = '0;
    alarm_on       = 1'b0;
  endfunction

  // advance the trigger state by one frame and return the result it gives
  function automatic frame_verdict_t judge_frame(logic signed [MOTION_WIDTH-1:0] mx,
                                                 logic signed [MOTION_WIDTH-1:0] my,
                                                 logic [TIME_WIDTH-1:0] t_ms);
    logic [SUM_WIDTH-1:0] total;
    logic                 go;
    logic                 flush;
    frame_verdict_t       v;
    total = abs_q88(mx) + abs_q88(my);
    go    = total > {settings.motion_thr, 1'b0};
    flush = total > {settings.flow_thr, 1'b0};
    v.snd_start = 1'b0;
    v.snd_stop  = 1'b0;
    if (expired(t_ms, hit_mark_ms, settings.timeout_ms)) hits = '0;
    if (!alarm_on && go) begin
      if (hits < settings.frames_trig) begin
        hits        = hits + 1'b1;
        hit_mark_ms = t_ms;
      end else begin
        motion_mark_ms = t_ms;
        alarm_on       = 1'b1;
        v.snd_start    = 1'b1;
      end
    end else if (alarm_on && go) begin
      motion_mark_ms = t_ms;
    end else if (alarm_on && expired(t_ms, motion_mark_ms, settings.hold_ms)) begin
      alarm_on   = 1'b0;
      v.snd_stop = 1'b1;
    end
    // flow reset forces the trigger off
    if (flush) begin
      if (alarm_on) v.snd_stop = 1'b1;
      alarm_on = 1'b0;
    end
    v.triggered = alarm_on;
    v.level     = total[SUM_WIDTH-1:1];
    v.moving    = go;
    v.flow_rst  = flush;
    return v;
  endfunction

  // ---------------------------------------------------------------- drivers

  // offer one frame, wait for the request to be taken, then maybe idle
  task automatic push_frame(input logic signed [MOTION_WIDTH-1:0] mx,
                            input logic signed [MOTION_WIDTH-1:0] my,
                            input logic [TIME_WIDTH-1:0] t_ms);
    int gap;
    in_tdata  <= {t_ms, my, mx};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_verdicts.push_back(judge_frame(mx, my, t_ms));
    if (burst_left == 0) begin
      gap = $urandom_range(gap_max, 0);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(12, 1);
    end else begin
      burst_left--;
    end
  endtask

  // stop offering and wait until every pending result has arrived
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  // cfg_valid stays high across back-to-back writes; set_regs lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MOTION_THR:  settings.motion_thr  = data;
      REG_FLOW_THR:    settings.flow_thr    = data;
      REG_FRAMES_TRIG: settings.frames_trig = data[CNT_WIDTH-1:0];
      REG_HOLD_MS:     settings.hold_ms     = data;
      REG_TIMEOUT_MS:  settings.timeout_ms  = data;
      default: ;
    endcase
  endtask

  task automatic set_regs(input cfg_t c);
    write_reg(REG_MOTION_THR, c.motion_thr);
    write_reg(REG_FLOW_THR, c.flow_thr);
    write_reg(REG_FRAMES_TRIG, CFG_DATA_W'(c.frames_trig));
    write_reg(REG_HOLD_MS, c.hold_ms);
    write_reg(REG_TIMEOUT_MS, c.timeout_ms);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- stimulus shaping

  // pick |x|+|y| for the wanted kind of frame under the current thresholds
  function automatic int unsigned pick_sum(sum_kind_t k);
    int unsigned lo;
    int unsigned hi;
    int          border;
    case (k)
      SUM_MOVING: begin
        lo = 2 * settings.motion_thr + 1;
        if (lo > SUM_MAX) return $urandom_range(SUM_MAX, 0);
        hi = (2 * settings.flow_thr >= lo) ? 2 * settings.flow_thr : SUM_MAX;
        if (hi > SUM_MAX) hi = SUM_MAX;
        return $urandom_range(hi, lo);
      end
      SUM_FLOW: begin
        lo = 2 * settings.flow_thr + 1;
        if (lo > SUM_MAX) return SUM_MAX;
        return $urandom_range(SUM_MAX, lo);
      end
      SUM_BORDER: begin
        border = $urandom_range(1, 0) ? 2 * settings.motion_thr : 2 * settings.flow_thr;
        border = border + $urandom_range(2, 0) - 1;
        if (border < 0) border = 0;
        if (border > SUM_MAX) border = SUM_MAX;
        return border;
      end
      default: begin
        hi = 2 * settings.motion_thr;
        if (hi > SUM_MAX) hi = SUM_MAX;
        return $urandom_range(hi, 0);
      end
    endcase
  endfunction

  function automatic logic signed [MOTION_WIDTH-1:0] signed_mag(int unsigned m);
    if (m == HALF_MAG || $urandom_range(1, 0)) return MOTION_WIDTH'(-int'(m));
    return MOTION_WIDTH'(m);
  endfunction

  // step the frame clock: mostly forward, sometimes far, back, to a random value or near the top
  task automatic next_time();
    int unsigned span;
    int unsigned r;
    span = (settings.hold_ms > settings.timeout_ms) ? settings.hold_ms : settings.timeout_ms;
    r = $urandom_range(99, 0);
    if (r < 80)      t_now = t_now + $urandom_range(span / 4 + 2, 0);
    else if (r < 88) t_now = t_now + span + $urandom_range(span + 2, 0);
    else if (r < 93) t_now = t_now - $urandom_range(span + 5, 0);
    else if (r < 97) t_now = $urandom;
    else             t_now = '1 - $urandom_range(span, 0);
  endtask

  task automatic send_kind(input sum_kind_t k);
    int unsigned total;
    int unsigned a;
    int unsigned a_lo;
    int unsigned a_hi;
    if (k == SUM_NOISE) begin
      push_frame(MOTION_WIDTH'($urandom), MOTION_WIDTH'($urandom), TIME_WIDTH'($urandom));
    end else begin
      total = pick_sum(k);
      a_lo  = (total > HALF_MAG) ? total - HALF_MAG : 0;
      a_hi  = (total < HALF_MAG) ? total : HALF_MAG;
      a     = $urandom_range(a_hi, a_lo);
      next_time();
      push_frame(signed_mag(a), signed_mag(total - a), t_now);
    end
  endtask

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    frame_verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        $error("result with no frame pending: %h", out_tdata);
      end else begin
        want = pending_verdicts.pop_front();
        check_field("triggered", want.triggered, out_tdata[0]);
        check_field("motion_level", want.level, out_tdata[MOTION_WIDTH:1]);
        check_field("moving", want.moving, out_tdata[MOTION_WIDTH+1]);
        check_field("sound_start", want.snd_start, out_tdata[MOTION_WIDTH+2]);
        check_field("sound_stop", want.snd_stop, out_tdata[MOTION_WIDTH+3]);
        check_field("flow_reset", want.flow_rst, out_tdata[MOTION_WIDTH+4]);
        check_field("pad", '0, out_tdata[OUT_DATA_W-1:OUT_RAW_W]);
      end
    end
  end

  // receiver: short random stalls, or a long hold-off when one is requested
  initial forever begin
    @(posedge clk);
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(4, 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- tests

  // reset values; counting, trigger, hold drop, flow reset, backward and wrapping time
  task automatic test_reset_values();
    push_frame(0, 0, 10);
    push_frame(128, 128, 20);           // sum equals twice the threshold: not moving
    push_frame(129, 128, 30);
    push_frame(200, -100, 60);
    push_frame(-300, 0, 90);
    push_frame(0, -257, 120);           // count reached: trigger on
    push_frame(0, 0, 5120);             // hold exactly elapsed: stay on
    push_frame(0, 0, 5121);             // hold exceeded: drop
    push_frame(512, 0, 5200);
    push_frame(513, 0, 5210);           // flow reset while off
    push_frame(300, 300, 5220);
    push_frame(-32768, -32768, 5230);   // most negative: start and flow reset together
    push_frame(32767, 32767, 5240);
    push_frame(200, 0, 100);            // time goes backwards
    push_frame(300, 0, 5250);
    push_frame(0, 0, 10);
    push_frame(0, 0, 32'hFFFF_FFFF);
    push_frame(300, 0, 32'hFFFF_FF00);
    push_frame(300, 0, 32'hFFFF_FFFF);  // mark plus timeout passes 2^32
  endtask

  // zero frames to trigger: the first moving frame triggers
  task automatic test_zero_frames();
    cfg_t c;
    c.motion_thr  = '0;
    c.flow_thr    = '1;
    c.frames_trig = '0;
    c.hold_ms     = '0;
    c.timeout_ms  = '0;
    drain_results();
    set_regs(c);
    push_frame(1, 0, 100);
    push_frame(0, 0, 100);
    push_frame(0, 0, 101);
  endtask

  // top thresholds and delays: nothing can move
  task automatic test_threshold_extremes();
    cfg_t c;
    c.motion_thr  = '1;
    c.flow_thr    = '1;
    c.frames_trig = '1;
    c.hold_ms     = '1;
    c.timeout_ms  = '1;
    drain_results();
    set_regs(c);
    push_frame(-32768, -32768, 1);
    push_frame(32767, -32768, 2);
  endtask

  // long receiver hold-off while frames keep coming, then let the block empty
  task automatic test_backpressure();
    drain_results();
    gap_max   = 0;
    stall_pct = 0;
    hold_left = 300;
    repeat (30) send_kind($urandom_range(1, 0) ? SUM_MOVING : SUM_QUIET);
    drain_results();
  endtask

  // phases of random or extreme settings; most frames come as motion, quiet or flow episodes
  task automatic test_random_phases();
    cfg_t      c;
    int        n;
    int        run;
    int        r;
    int        quota;
    sum_kind_t k;
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      case (ph)
        2: begin
          c.motion_thr  = '0;
          c.flow_thr    = '1;
          c.frames_trig = '1;
          c.hold_ms     = '1;
          c.timeout_ms  = '1;
        end
        5: begin
          c.motion_thr  = '1;
          c.flow_thr    = '0;
          c.frames_trig = '0;
          c.hold_ms     = '0;
          c.timeout_ms  = '0;
        end
        3, 7: begin
          c.motion_thr  = THR_WIDTH'($urandom);
          c.flow_thr    = THR_WIDTH'($urandom);
          c.frames_trig = CNT_WIDTH'($urandom);
          c.hold_ms     = DLY_WIDTH'($urandom);
          c.timeout_ms  = DLY_WIDTH'($urandom);
        end
        default: begin
          c.motion_thr  = THR_WIDTH'($urandom_range(1200, 0));
          c.flow_thr    = $urandom_range(1, 0)
                          ? THR_WIDTH'(c.motion_thr + $urandom_range(2500, 0))
                          : THR_WIDTH'($urandom_range(1500, 0));
          c.frames_trig = CNT_WIDTH'($urandom_range(6, 0));
          c.hold_ms     = DLY_WIDTH'($urandom_range(300, 0));
          c.timeout_ms  = DLY_WIDTH'($urandom_range(200, 0));
        end
      endcase
      set_regs(c);
      gap_max   = (ph == 0) ? 0 : $urandom_range(6, 0);
      stall_pct = (ph == 0) ? 0 : $urandom_range(50, 0);
      quota     = (ph == 2) ? 320 : 120;
      n = 0;
      while (n < quota) begin
        r = $urandom_range(99, 0);
        if (r < 50) begin
          k   = SUM_MOVING;
          run = $urandom_range(settings.frames_trig + 3, 1);
        end else if (r < 75) begin
          k   = SUM_QUIET;
          run = $urandom_range(6, 1);
        end else if (r < 83) begin
          k   = SUM_FLOW;
          run = $urandom_range(2, 1);
        end else if (r < 90) begin
          k   = SUM_BORDER;
          run = $urandom_range(3, 1);
        end else begin
          k   = SUM_NOISE;
          run = $urandom_range(3, 1);
        end
        repeat (run) send_kind(k);
        n += run;
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_zero_frames();
    test_threshold_extremes();
    test_backpressure();
    test_random_phases();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
